// ----- rtl/zbr_pkg.sv -----
// Shared types and constants for the z-buffered triangle rasterizer.
package zbr_pkg;

  localparam int FRAME_DIM_DEFAULT = 256;
  localparam int TEX_DIM_DEFAULT   = 64;

  // Q12.4 coordinate minus a pixel centre needs 17 signed bits over the whole
  // frame range; the edge function is a difference of two such products.
  localparam int DIFF_W = 17;
  localparam int EDGE_W = 2 * DIFF_W + 1;

  localparam logic [2:0] KIND_CLEAR  = 3'd0;
  localparam logic [2:0] KIND_TEXEL  = 3'd1;
  localparam logic [2:0] KIND_VERTEX = 3'd2;
  localparam logic [2:0] KIND_DRAW   = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TEX_WIDTH    = 2'd2;
  localparam logic [1:0] REG_TEX_HEIGHT   = 2'd3;

  localparam logic [1:0] SLOT_NONE = 2'd3;

  localparam logic [8:0] FRAME_WIDTH_RESET  = 9'd256;
  localparam logic [8:0] FRAME_HEIGHT_RESET = 9'd256;
  localparam logic [6:0] TEX_WIDTH_RESET    = 7'd64;
  localparam logic [6:0] TEX_HEIGHT_RESET   = 7'd64;

  // Adding 2^23 modulo 2^24 flips the top bit of a 24-bit coordinate.
  localparam logic [23:0] UV_BIAS = 24'h800000;

  typedef struct packed {
    logic [2:0]         kind;
    logic [1:0]         slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        vert_depth;
    logic signed [23:0] tex_u;
    logic signed [23:0] tex_v;
    logic [31:0]        vert_color;
    logic               textured;
    logic [15:0]        address;
    logic [31:0]        texel_data;
  } zbr_cmd_t;

  typedef struct packed {
    logic [31:0] pixel_color;
    logic [31:0] pixel_depth;
    logic [16:0] pixels_passed;
  } zbr_rsp_t;

  typedef struct packed {
    logic [2:0][EDGE_W-1:0] e;
    logic [EDGE_W-1:0]      d;
    logic [2:0][31:0]       v;
  } zbr_interp_req_t;

endpackage

// ----- rtl/zbr_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
module zbr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/zbr_interp.sv -----
// Barycentric interpolator: sequential multiply-accumulate, then restoring divide.
module zbr_interp import zbr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  zbr_interp_req_t req,
  output logic            done,
  output logic [31:0]     q
);

  localparam int EW = EDGE_W;
  localparam int SW = EW + 34;
  localparam int RW = EW + 1;
  localparam int TW = RW + 1;
  localparam logic [4:0] MUL_STEPS = 5'd6;

  typedef enum logic [1:0] {I_IDLE, I_MUL, I_PREP, I_DIV} istate_t;

  istate_t         st;
  logic [4:0]      cnt;
  zbr_interp_req_t req_r;
  logic [63:0]     prod;
  logic            prod_hi;
  logic [SW-1:0]   acc;
  logic [RW-1:0]   r;
  logic [31:0]     lo;

  logic [1:0]      mi;
  logic [31:0]     mop;
  logic [TW-1:0]   t;
  logic [TW-1:0]   dext;

  always_comb begin
    mi   = cnt[2:1];
    mop  = cnt[0] ? 32'(req_r.e[mi][EW-1:32]) : req_r.e[mi][31:0];
    t    = {r, lo[31]};
    dext = TW'(req_r.d);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= I_IDLE;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      case (st)
        I_IDLE: begin
          if (start) begin
            req_r <= req;
            acc   <= '0;
            cnt   <= '0;
            st    <= I_MUL;
          end
        end
        I_MUL: begin
          // one partial product per cycle, added to the accumulator in the cycle after
          if (cnt < MUL_STEPS) begin
            prod    <= mop * req_r.v[mi];
            prod_hi <= cnt[0];
          end
          if (cnt != '0) begin
            acc <= acc + (prod_hi ? SW'({prod, 32'h0}) : SW'(prod));
          end
          if (cnt == MUL_STEPS) begin
            st <= I_PREP;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        I_PREP: begin
          r   <= acc[32 +: RW];
          lo  <= acc[31:0];
          cnt <= 5'd31;
          st  <= I_DIV;
        end
        I_DIV: begin
          if (t >= dext) begin
            r <= RW'(t - dext);
            q <= {q[30:0], 1'b1};
          end else begin
            r <= t[RW-1:0];
            q <= {q[30:0], 1'b0};
          end
          lo <= {lo[30:0], 1'b0};
          if (cnt == '0) begin
            done <= 1'b1;
            st   <= I_IDLE;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        default: st <= I_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/zbuffer_triangle_rasterizer.sv -----
// Top level: command sequencer, edge unit, frame/depth/texture memories.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  cmd     | in        | cmd_valid / cmd_ready   | zbr_cmd_t (one command)
//  rsp     | out       | rsp_valid / rsp_ready   | zbr_rsp_t (one per command)
//  cfg     | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One command at a time. Vertex load, texel write, unknown kind: straight to
// the response. Pixel read: a RAM read state first. Clear: one buffer entry a
// cycle over the whole buffer. Draw: setup and an area pass, then per pixel of
// the clipped box an edge pass; a pixel inside runs the interpolator (32-step
// divider) for depth, a passing textured one twice more for u and v, then a texel read.
// After reset every entry of the color and depth buffers is swept with
// cmd_ready low; cfg writes are taken at any time.
// A stalled rsp holds the finished transaction; cmd_ready returns once it is
// in the output register.
module zbuffer_triangle_rasterizer import zbr_pkg::*; #(
  parameter int FRAME_DIM = FRAME_DIM_DEFAULT,
  parameter int TEX_DIM   = TEX_DIM_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  zbr_cmd_t   cmd,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output zbr_rsp_t   rsp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int FRAME_PIX = FRAME_DIM * FRAME_DIM;
  localparam int PIXW      = $clog2(FRAME_PIX);
  localparam int TEX_WORDS = TEX_DIM * TEX_DIM;
  localparam int TIW       = $clog2(TEX_WORDS);
  localparam int CW        = $clog2(FRAME_DIM + 1);
  localparam int TCW       = $clog2(TEX_DIM + 1);
  localparam int BW        = 14;
  localparam int DW        = DIFF_W;
  localparam logic [2:0] EDGE_STEPS = 3'd6;

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_RD, S_SETUP, S_EDGE, S_EDGE_DONE, S_I_GO, S_I_WAIT,
    S_ZRD, S_ZCMP, S_TEXA, S_TEXI, S_TEXRD, S_TEXW, S_NEXT, S_FINISH
  } state_t;

  typedef enum logic [1:0] {SEL_Z, SEL_U, SEL_V} sel_t;

  state_t state;
  sel_t   vsel;

  // configuration registers
  logic [8:0] frame_width, frame_height;
  logic [6:0] tex_width, tex_height;

  // vertex state
  logic signed [15:0] vx [3];
  logic signed [15:0] vy [3];
  logic [31:0]        vz [3];
  logic [23:0]        vu [3];
  logic [23:0]        vv [3];
  logic [31:0]        lead_color;

  // command context
  logic        sweep_item;
  logic [PIXW-1:0] sweep_cnt;
  logic        rd_ok;
  logic        textured;

  // draw context
  logic [CW-1:0]   w_r;
  logic [TCW-1:0]  tw_r, th_r;
  logic [CW-1:0]   x0, x1, y0, y1, x, y;
  logic            box_empty;
  logic [PIXW-1:0] row_base;
  logic            area_pass, area_neg;
  logic [2:0]      ecnt;
  logic signed [2*DW-1:0]   eprod, etmp;
  logic signed [EDGE_W-1:0] s [3];
  logic [EDGE_W-1:0]        e_r [3];
  logic [EDGE_W-1:0]        d_r;
  logic [31:0]     zq;
  logic [15:0]     fu, fv;
  logic [TCW-1:0]  tu, tv;
  logic [TIW-1:0]  tex_index;

  // results
  logic [31:0] res_color, res_depth;
  logic [16:0] passed;

  // memories
  logic            fb_we_color, fb_we_depth, tex_we;
  logic [PIXW-1:0] fb_addr;
  logic [TIW-1:0]  tex_addr;
  logic [31:0]     color_wdata, depth_wdata, color_rdata, depth_rdata, tex_rdata;

  // interpolator
  logic            i_start, i_done;
  logic [31:0]     i_q;
  zbr_interp_req_t i_req;

  logic cmd_fire;
  assign cmd_ready = (state == S_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------
  // Register clamps and bounding box
  // ---------------------------------------------------------------------
  logic [CW-1:0]  w_c, h_c;
  logic [TCW-1:0] tw_c, th_c;

  always_comb begin
    if (frame_width == '0) w_c = CW'(1);
    else if (32'(frame_width) > FRAME_DIM) w_c = CW'(FRAME_DIM);
    else w_c = CW'(frame_width);
    if (frame_height == '0) h_c = CW'(1);
    else if (32'(frame_height) > FRAME_DIM) h_c = CW'(FRAME_DIM);
    else h_c = CW'(frame_height);
    if (tex_width == '0) tw_c = TCW'(1);
    else if (32'(tex_width) > TEX_DIM) tw_c = TCW'(TEX_DIM);
    else tw_c = TCW'(tex_width);
    if (tex_height == '0) th_c = TCW'(1);
    else if (32'(tex_height) > TEX_DIM) th_c = TCW'(TEX_DIM);
    else th_c = TCW'(tex_height);
  end

  // Q12.4 to integer, rounding toward zero
  function automatic logic signed [BW-1:0] trunc4(input logic signed [15:0] q);
    logic signed [16:0] qe;
    logic [16:0]        m;
    logic signed [BW-1:0] res;
    qe = q;
    m  = 17'(-qe);
    if (q[15]) res = -$signed(BW'(m[16:4]));
    else res = BW'(q >>> 4);
    return res;
  endfunction

  logic signed [BW-1:0] bx0, bx1, by0, by1, ws, hs, tx, ty;

  always_comb begin
    ws  = $signed(BW'(w_c));
    hs  = $signed(BW'(h_c));
    bx0 = ws;
    bx1 = '0;
    by0 = hs;
    by1 = '0;
    for (int i = 0; i < 3; i++) begin
      tx = trunc4(vx[i]);
      ty = trunc4(vy[i]);
      if (tx < bx0) bx0 = tx;
      if (tx > bx1) bx1 = tx;
      if (ty < by0) by0 = ty;
      if (ty > by1) by1 = ty;
    end
    if (bx0 < 0) bx0 = '0;
    if (by0 < 0) by0 = '0;
    if (bx1 >= ws) bx1 = ws - BW'(1);
    if (by1 >= hs) by1 = hs - BW'(1);
  end

  // ---------------------------------------------------------------------
  // Edge unit: one signed product a cycle, six per pass
  // ---------------------------------------------------------------------
  logic [1:0]             ei, ej, ek;
  logic [2:0]             eprev;
  logic signed [DW-1:0]   fxs, fys, opa, opb;
  logic signed [EDGE_W+1:0] asum;
  logic signed [EDGE_W-1:0] ns [3];
  logic                   in_tri;

  always_comb begin
    ei = ecnt[2:1];
    case (ei)
      2'd0:    begin ej = 2'd1; ek = 2'd2; end
      2'd1:    begin ej = 2'd2; ek = 2'd0; end
      default: begin ej = 2'd0; ek = 2'd1; end
    endcase
    eprev = ecnt - 3'd1;
    if (area_pass) begin
      fxs = '0;
      fys = '0;
    end else begin
      fxs = $signed(DW'({x, 4'h8}));
      fys = $signed(DW'({y, 4'h8}));
    end
    if (!ecnt[0]) begin
      opa = DW'(vx[ej]) - fxs;
      opb = DW'(vy[ek]) - fys;
    end else begin
      opa = DW'(vy[ej]) - fys;
      opb = DW'(vx[ek]) - fxs;
    end
    // the edge functions of the triangle sum to its signed parallelogram area at any point
    asum   = (EDGE_W+2)'(s[0]) + (EDGE_W+2)'(s[1]) + (EDGE_W+2)'(s[2]);
    in_tri = 1'b1;
    for (int i = 0; i < 3; i++) begin
      ns[i] = area_neg ? -s[i] : s[i];
      if (ns[i] < 0) in_tri = 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Texture address and color modulation
  // ---------------------------------------------------------------------
  logic [24:0] pu, pv;
  logic [31:0] modc;
  logic [15:0] chp;
  logic        zpass;
  logic [PIXW-1:0] pix;

  always_comb begin
    pu = 25'(fu) * 25'(tw_r);
    pv = 25'(fv) * 25'(th_r);
    for (int c = 0; c < 4; c++) begin
      chp = 16'(tex_rdata[c*8 +: 8]) * 16'(lead_color[c*8 +: 8]);
      modc[c*8 +: 8] = chp[15:8];
    end
    zpass = zq < depth_rdata;
    pix   = row_base + PIXW'(x);
  end

  // ---------------------------------------------------------------------
  // Memory ports
  // ---------------------------------------------------------------------
  always_comb begin
    case (state)
      S_SWEEP: fb_addr = sweep_cnt;
      S_IDLE:  fb_addr = PIXW'(cmd.address);
      default: fb_addr = pix;
    endcase
    fb_we_depth = (state == S_SWEEP) || (state == S_ZCMP && zpass);
    depth_wdata = (state == S_SWEEP) ? '1 : zq;
    fb_we_color = (state == S_SWEEP)
               || (state == S_ZCMP && zpass && !textured)
               || (state == S_TEXW && modc[31:24] != 8'h00);
    case (state)
      S_SWEEP: color_wdata = '0;
      S_ZCMP:  color_wdata = {8'hFF, lead_color[23:0]};
      default: color_wdata = modc;
    endcase
    tex_we   = cmd_fire && cmd.kind == KIND_TEXEL && 32'(cmd.address) < TEX_WORDS;
    tex_addr = (state == S_IDLE) ? TIW'(cmd.address) : tex_index;
  end

  zbr_ram #(.WIDTH(32), .DEPTH(FRAME_PIX)) u_color_ram (
    .clk(clk), .we(fb_we_color), .addr(fb_addr), .wdata(color_wdata), .rdata(color_rdata)
  );

  zbr_ram #(.WIDTH(32), .DEPTH(FRAME_PIX)) u_depth_ram (
    .clk(clk), .we(fb_we_depth), .addr(fb_addr), .wdata(depth_wdata), .rdata(depth_rdata)
  );

  zbr_ram #(.WIDTH(32), .DEPTH(TEX_WORDS)) u_tex_ram (
    .clk(clk), .we(tex_we), .addr(tex_addr), .wdata(cmd.texel_data), .rdata(tex_rdata)
  );

  // ---------------------------------------------------------------------
  // Interpolator request: same weights, value set picked by vsel
  // ---------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      i_req.e[i] = e_r[i];
      case (vsel)
        SEL_U:   i_req.v[i] = {8'h00, vu[i] ^ UV_BIAS};
        SEL_V:   i_req.v[i] = {8'h00, vv[i] ^ UV_BIAS};
        default: i_req.v[i] = vz[i];
      endcase
    end
    i_req.d = d_r;
    i_start = (state == S_I_GO);
  end

  zbr_interp u_interp (
    .clk(clk), .rst(rst), .start(i_start), .req(i_req), .done(i_done), .q(i_q)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SWEEP;
      sweep_cnt    <= '0;
      sweep_item   <= 1'b0;
      rsp_valid    <= 1'b0;
      vsel         <= SEL_Z;
      ecnt         <= '0;
      area_pass    <= 1'b0;
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
      tex_width    <= TEX_WIDTH_RESET;
      tex_height   <= TEX_HEIGHT_RESET;
      lead_color   <= '0;
      for (int i = 0; i < 3; i++) begin
        vx[i] <= '0;
        vy[i] <= '0;
        vz[i] <= '0;
        vu[i] <= '0;
        vv[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_width  <= cfg_data;
          REG_FRAME_HEIGHT: frame_height <= cfg_data;
          REG_TEX_WIDTH:    tex_width    <= cfg_data[6:0];
          REG_TEX_HEIGHT:   tex_height   <= cfg_data[6:0];
          default: ;
        endcase
      end

      // drop the output transaction once taken; the finish state reloads it
      if (rsp_valid && rsp_ready && state != S_FINISH) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_SWEEP: begin
          if (sweep_cnt == PIXW'(FRAME_PIX - 1)) begin
            state <= sweep_item ? S_FINISH : S_IDLE;
          end
          sweep_cnt <= sweep_cnt + PIXW'(1);
        end

        S_IDLE: begin
          if (cmd_fire) begin
            res_color <= '0;
            res_depth <= '0;
            passed    <= '0;
            case (cmd.kind)
              KIND_CLEAR: begin
                sweep_cnt  <= '0;
                sweep_item <= 1'b1;
                state      <= S_SWEEP;
              end
              KIND_VERTEX: begin
                if (cmd.slot != SLOT_NONE) begin
                  vx[cmd.slot] <= cmd.pos_x;
                  vy[cmd.slot] <= cmd.pos_y;
                  vz[cmd.slot] <= cmd.vert_depth;
                  vu[cmd.slot] <= cmd.tex_u;
                  vv[cmd.slot] <= cmd.tex_v;
                  if (cmd.slot == 2'd0) lead_color <= cmd.vert_color;
                end
                state <= S_FINISH;
              end
              KIND_DRAW: begin
                textured <= cmd.textured;
                state    <= S_SETUP;
              end
              KIND_READ: begin
                rd_ok <= 32'(cmd.address) < FRAME_PIX;
                state <= S_RD;
              end
              default: state <= S_FINISH;
            endcase
          end
        end

        S_RD: begin
          if (rd_ok) begin
            res_color <= color_rdata;
            res_depth <= depth_rdata;
          end
          state <= S_FINISH;
        end

        S_SETUP: begin
          w_r       <= w_c;
          tw_r      <= tw_c;
          th_r      <= th_c;
          x0        <= CW'(bx0);
          x1        <= CW'(bx1);
          y0        <= CW'(by0);
          y1        <= CW'(by1);
          // judge emptiness on the signed box, before it is narrowed
          box_empty <= (bx0 > bx1) || (by0 > by1);
          area_pass <= 1'b1;
          ecnt      <= '0;
          state     <= S_EDGE;
        end

        S_EDGE: begin
          if (ecnt < EDGE_STEPS) begin
            eprod <= opa * opb;
          end
          if (ecnt != '0) begin
            if (!eprev[0]) etmp <= eprod;
            else s[eprev[2:1]] <= etmp - eprod;
          end
          if (ecnt == EDGE_STEPS) state <= S_EDGE_DONE;
          else ecnt <= ecnt + 3'd1;
        end

        S_EDGE_DONE: begin
          ecnt <= '0;
          if (area_pass) begin
            // degenerate triangle or empty box: nothing to draw
            if (asum == '0 || box_empty) begin
              state <= S_FINISH;
            end else begin
              area_neg  <= asum < 0;
              d_r       <= (asum < 0) ? EDGE_W'(-asum) : EDGE_W'(asum);
              x         <= x0;
              y         <= y0;
              row_base  <= PIXW'(y0) * PIXW'(w_r);
              area_pass <= 1'b0;
              state     <= S_EDGE;
            end
          end else if (in_tri) begin
            for (int i = 0; i < 3; i++) e_r[i] <= EDGE_W'(ns[i]);
            vsel  <= SEL_Z;
            state <= S_I_GO;
          end else begin
            state <= S_NEXT;
          end
        end

        S_I_GO: state <= S_I_WAIT;

        S_I_WAIT: begin
          if (i_done) begin
            case (vsel)
              SEL_Z: begin
                zq    <= i_q;
                state <= S_ZRD;
              end
              SEL_U: begin
                fu    <= i_q[15:0];
                vsel  <= SEL_V;
                state <= S_I_GO;
              end
              SEL_V: begin
                fv    <= i_q[15:0];
                state <= S_TEXA;
              end
              default: state <= S_NEXT;
            endcase
          end
        end

        S_ZRD: state <= S_ZCMP;

        S_ZCMP: begin
          if (zpass) begin
            passed <= passed + 17'd1;
            if (textured) begin
              vsel  <= SEL_U;
              state <= S_I_GO;
            end else begin
              state <= S_NEXT;
            end
          end else begin
            state <= S_NEXT;
          end
        end

        S_TEXA: begin
          tu    <= (pu[24:16] >= 9'(tw_r)) ? tw_r - TCW'(1) : TCW'(pu[24:16]);
          tv    <= (pv[24:16] >= 9'(th_r)) ? th_r - TCW'(1) : TCW'(pv[24:16]);
          state <= S_TEXI;
        end

        S_TEXI: begin
          tex_index <= TIW'(tv) * TIW'(tw_r) + TIW'(tu);
          state     <= S_TEXRD;
        end

        S_TEXRD: state <= S_TEXW;

        S_TEXW: state <= S_NEXT;

        S_NEXT: begin
          if (x == x1) begin
            if (y == y1) begin
              state <= S_FINISH;
            end else begin
              y        <= y + CW'(1);
              x        <= x0;
              row_base <= row_base + PIXW'(w_r);
              state    <= S_EDGE;
            end
          end else begin
            x     <= x + CW'(1);
            state <= S_EDGE;
          end
        end

        S_FINISH: begin
          // hold until the output register is free
          if (!rsp_valid || rsp_ready) begin
            rsp_valid         <= 1'b1;
            rsp.pixel_color   <= res_color;
            rsp.pixel_depth   <= res_depth;
            rsp.pixels_passed <= passed;
            state             <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/zbr_checker.sv -----
// Port-level checks for the rasterizer, bound to the top level.
module zbr_checker import zbr_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     cmd_valid,
  input logic     cmd_ready,
  input logic     rsp_valid,
  input logic     rsp_ready,
  input zbr_rsp_t rsp
);

  // reset starts the buffer sweep and empties the output register
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !cmd_ready && !rsp_valid)
    else $error("ready or rsp_valid high right after reset");

  // one command at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("cmd_ready stayed high after an accepted transaction");

  // a new result only appears while no command is being taken
  a_rsp_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(cmd_ready))
    else $error("result appeared without a command in flight");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed or dropped");

endmodule

bind zbuffer_triangle_rasterizer zbr_checker u_zbr_checker (
  .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
  .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);
